>>> rtl/multi_channel_phase_angle_dimmer_assert.svh
`ifndef MULTI_CHANNEL_PHASE_ANGLE_DIMMER_ASSERT_SVH
`define MULTI_CHANNEL_PHASE_ANGLE_DIMMER_ASSERT_SVH

// same-cycle implication
`define MCPAD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mcpad assertion failed");

// next-cycle implication
`define MCPAD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mcpad assertion failed");

`endif

>>> rtl/mcpad_pkg.sv
package mcpad_pkg;

  localparam int unsigned CHANNELS   = 8;
  localparam int unsigned GATE_W     = 8;
  localparam int unsigned PADDR_W    = 5;
  localparam int unsigned THIRD_W    = 15;
  localparam int unsigned SUM_W      = 17;
  localparam int unsigned QUOT_W     = 11;

  localparam logic [2:0] REG_LEVELS_LO      = 3'd0;
  localparam logic [2:0] REG_LEVELS_HI      = 3'd1;
  localparam logic [2:0] REG_DIRECT_MASK    = 3'd2;
  localparam logic [2:0] REG_DEFAULT_CUTOFF = 3'd3;
  localparam logic [2:0] REG_PERIOD_FLOOR   = 3'd4;
  localparam logic [2:0] REG_PERIOD_CEIL    = 3'd5;
  localparam logic [2:0] REG_CUTOFF_MARGIN  = 3'd6;

  localparam logic [31:0] RST_LEVELS         = 32'hffff_ffff;
  localparam logic [7:0]  RST_DIRECT_MASK    = 8'd0;
  localparam logic [15:0] RST_DEFAULT_CUTOFF = 16'd231;
  localparam logic [15:0] RST_PERIOD_FLOOR   = 16'd18182;
  localparam logic [15:0] RST_PERIOD_CEIL    = 16'd22222;
  localparam logic [15:0] RST_CUTOFF_MARGIN  = 16'd20;

  // one third of the 20000 reset half-period
  localparam logic [THIRD_W-1:0] RST_HIST_THIRD = 15'd6666;

  // x / 3 == (x * 43691) >> 17 for every 16-bit x
  localparam logic [16:0] RECIP3       = 17'd43691;
  localparam int unsigned RECIP3_SHIFT = 17;
  // x / 80 == ((x >> 4) * 3277) >> 14 for x below 2^17
  localparam int unsigned DIV16_SHIFT  = 4;
  localparam logic [11:0] RECIP5       = 12'd3277;
  localparam int unsigned RECIP5_SHIFT = 14;

  typedef struct packed {
    logic [63:0] levels;
    logic [7:0]  direct_mask;
    logic [15:0] default_cutoff;
    logic [15:0] period_floor;
    logic [15:0] period_ceil;
    logic [15:0] cutoff_margin;
  } cfg_t;

  typedef struct packed {
    logic               crossing;
    logic               in_window;
    logic [THIRD_W-1:0] third;
  } item_t;

endpackage

>>> rtl/mcpad_cfg_regs.sv
module mcpad_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mcpad_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output mcpad_pkg::cfg_t                cfg_o
);
  import mcpad_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[PADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_LEVELS_LO:      cfg_d.levels[31:0]    = pwdata;
        REG_LEVELS_HI:      cfg_d.levels[63:32]   = pwdata;
        REG_DIRECT_MASK:    cfg_d.direct_mask     = pwdata[7:0];
        REG_DEFAULT_CUTOFF: cfg_d.default_cutoff  = pwdata[15:0];
        REG_PERIOD_FLOOR:   cfg_d.period_floor    = pwdata[15:0];
        REG_PERIOD_CEIL:    cfg_d.period_ceil     = pwdata[15:0];
        REG_CUTOFF_MARGIN:  cfg_d.cutoff_margin   = pwdata[15:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LEVELS_LO:      prdata = cfg_q.levels[31:0];
      REG_LEVELS_HI:      prdata = cfg_q.levels[63:32];
      REG_DIRECT_MASK:    prdata = {24'd0, cfg_q.direct_mask};
      REG_DEFAULT_CUTOFF: prdata = {16'd0, cfg_q.default_cutoff};
      REG_PERIOD_FLOOR:   prdata = {16'd0, cfg_q.period_floor};
      REG_PERIOD_CEIL:    prdata = {16'd0, cfg_q.period_ceil};
      REG_CUTOFF_MARGIN:  prdata = {16'd0, cfg_q.cutoff_margin};
      default:            prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.levels         <= {RST_LEVELS, RST_LEVELS};
      cfg_q.direct_mask    <= RST_DIRECT_MASK;
      cfg_q.default_cutoff <= RST_DEFAULT_CUTOFF;
      cfg_q.period_floor   <= RST_PERIOD_FLOOR;
      cfg_q.period_ceil    <= RST_PERIOD_CEIL;
      cfg_q.cutoff_margin  <= RST_CUTOFF_MARGIN;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> rtl/mcpad_in_stage.sv
module mcpad_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mcpad_pkg::cfg_t  cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             kind_i,
  input  logic [15:0]      half_period_i,
  output logic             item_valid_o,
  input  logic             item_ready_i,
  output mcpad_pkg::item_t item_o
);
  import mcpad_pkg::*;

  logic        valid_q, valid_d;
  item_t       item_q, item_d;
  logic [32:0] prod3;

  assign prod3      = {16'd0, half_period_i} * {16'd0, RECIP3};
  assign in_ready_o = !valid_q || item_ready_i;

  always_comb begin
    item_d.crossing  = kind_i;
    item_d.in_window = (half_period_i > cfg_i.period_floor) &&
                       (half_period_i < cfg_i.period_ceil);
    item_d.third     = prod3[RECIP3_SHIFT +: THIRD_W];
    valid_d          = in_ready_o ? in_valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

>>> rtl/mcpad_core.sv
module mcpad_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mcpad_pkg::cfg_t                  cfg_i,
  input  logic                             item_valid_i,
  output logic                             item_ready_o,
  input  mcpad_pkg::item_t                 item_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [mcpad_pkg::GATE_W-1:0]     gate_bits_o,
  output logic                             active_o,
  output logic [15:0]                      cutoff_now_o
);
  import mcpad_pkg::*;

  logic [15:0]              count_q, count_d;
  logic                     running_q, running_d;
  logic                     delay_q, delay_d;
  logic [GATE_W-1:0]        gate_q, gate_d;
  logic [15:0]              cutoff_q, cutoff_d;
  logic [THIRD_W-1:0]       hist_q [2];
  logic [THIRD_W-1:0]       hist_d [2];
  logic                     seen_q, seen_d;

  logic                     out_valid_q;
  logic [GATE_W-1:0]        res_gate_q;
  logic                     res_active_q;
  logic [15:0]              res_cutoff_q;

  logic                     take;
  logic [SUM_W-1:0]         sum;
  logic [SUM_W-DIV16_SHIFT-1:0] sum16;
  logic [SUM_W-DIV16_SHIFT+11:0] prod5;
  logic [15:0]              quot;
  logic [15:0]              cutoff_new;
  logic [15:0]              count_inc;
  logic [GATE_W-1:0]        fire;

  assign item_ready_o = !out_valid_q || out_ready_i;
  assign take         = item_valid_i && item_ready_o;

  assign sum   = SUM_W'(hist_q[1]) + SUM_W'(item_i.third) + SUM_W'(hist_q[0]);
  assign sum16 = sum[SUM_W-1:DIV16_SHIFT];
  assign prod5 = (SUM_W-DIV16_SHIFT+12)'(sum16) * (SUM_W-DIV16_SHIFT+12)'(RECIP5);
  assign quot  = 16'(prod5[RECIP5_SHIFT +: QUOT_W]);
  assign cutoff_new = (quot > cfg_i.cutoff_margin) ? (quot - cfg_i.cutoff_margin) : 16'd0;

  assign count_inc = count_q + 16'd1;

  always_comb begin
    fire = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      fire[ch] = count_inc > {8'd0, cfg_i.levels[ch*8 +: 8]};
    end
  end

  always_comb begin
    count_d   = count_q;
    running_d = running_q;
    delay_d   = delay_q;
    gate_d    = gate_q;
    cutoff_d  = cutoff_q;
    hist_d    = hist_q;
    seen_d    = seen_q;
    if (item_i.crossing) begin
      running_d = 1'b1;
      delay_d   = 1'b1;
      count_d   = 16'd0;
      seen_d    = 1'b1;
      if (!seen_q) begin
        cutoff_d = cfg_i.default_cutoff;
      end else if (item_i.in_window) begin
        hist_d[0] = hist_q[1];
        hist_d[1] = item_i.third;
        cutoff_d  = cutoff_new;
      end
    end else if (running_q) begin
      if (delay_q) begin
        delay_d = 1'b0;
        count_d = 16'd0;
      end else if (count_q > cutoff_q) begin
        running_d = 1'b0;
        gate_d    = gate_q & cfg_i.direct_mask;
      end else begin
        count_d = count_inc;
        gate_d  = fire;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= 16'd0;
      running_q   <= 1'b0;
      delay_q     <= 1'b0;
      gate_q      <= '0;
      cutoff_q    <= RST_DEFAULT_CUTOFF;
      hist_q[0]   <= RST_HIST_THIRD;
      hist_q[1]   <= RST_HIST_THIRD;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        count_q   <= count_d;
        running_q <= running_d;
        delay_q   <= delay_d;
        gate_q    <= gate_d;
        cutoff_q  <= cutoff_d;
        hist_q    <= hist_d;
        seen_q    <= seen_d;
      end
      if (item_ready_o) begin
        out_valid_q <= item_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_gate_q   <= gate_d;
      res_active_q <= running_d && !delay_d;
      res_cutoff_q <= cutoff_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign gate_bits_o  = res_gate_q;
  assign active_o     = res_active_q;
  assign cutoff_now_o = res_cutoff_q;

endmodule

>>> rtl/multi_channel_phase_angle_dimmer.sv
// Channel   Handshake                        Payload
// in        in_valid_i / in_ready_o          kind_i, half_period_i
// out       out_valid_o / out_ready_i        gate_bits_o, active_o, cutoff_now_o
// config    psel, penable, pwrite / pready   paddr, pwdata, prdata
//
// One transaction per cycle unless the output stalls.
// Input register, then phase state and result register updated in one pass.
// The crossing path holds one multiply by the reciprocal of five for the tick scaling.
// rst_ni resets the phase state, history and config registers asynchronously to their defaults.
// A stalled output holds its result; an empty input register takes one more item, then stalls.
module multi_channel_phase_angle_dimmer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           kind_i,
  input  logic [15:0]                    half_period_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mcpad_pkg::GATE_W-1:0]   gate_bits_o,
  output logic                           active_o,
  output logic [15:0]                    cutoff_now_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mcpad_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import mcpad_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  logic  item_ready;

  mcpad_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mcpad_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .half_period_i (half_period_i),
    .item_valid_o  (item_valid),
    .item_ready_i  (item_ready),
    .item_o        (item)
  );

  mcpad_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .gate_bits_o  (gate_bits_o),
    .active_o     (active_o),
    .cutoff_now_o (cutoff_now_o)
  );

endmodule

>>> rtl/mcpad_checker.sv
`include "multi_channel_phase_angle_dimmer_assert.svh"

module mcpad_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           kind_i,
  input logic [15:0]                    half_period_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [mcpad_pkg::GATE_W-1:0]   gate_bits_o,
  input logic                           active_o,
  input logic [15:0]                    cutoff_now_o,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [mcpad_pkg::PADDR_W-1:0]  paddr,
  input logic [31:0]                    pwdata,
  input logic [31:0]                    prdata,
  input logic                           pready
);
  import mcpad_pkg::*;

  logic out_stall;

  assign out_stall = out_valid_o && !out_ready_i;

  `MCPAD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall,
    out_valid_o && $stable(gate_bits_o) && $stable(active_o) && $stable(cutoff_now_o))
  `MCPAD_ASSERT_IMP(a_empty_takes, clk_i, rst_ni, !out_valid_o, in_ready_o)
  `MCPAD_ASSERT_IMP(a_drains, clk_i, rst_ni,
    !$past(in_valid_i) && $past(out_ready_i) && !$past(in_valid_i, 2) && $past(out_ready_i, 2),
    !out_valid_o)
  `MCPAD_ASSERT_IMP(a_cfg_readback, clk_i, rst_ni,
    psel && !pwrite && $past(psel && penable && pwrite) && (paddr == $past(paddr)) &&
    (paddr[PADDR_W-1:2] == REG_DEFAULT_CUTOFF),
    prdata[15:0] == $past(pwdata[15:0]))

endmodule

bind multi_channel_phase_angle_dimmer mcpad_checker u_mcpad_checker (.*);
